// ----- rtl/core/char_lcd_nibble_refresh_top_defines.svh -----
// Assertion macros for the LCD refresh block
`ifndef CHAR_LCD_NIBBLE_REFRESH_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_REFRESH_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLNR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CLNR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/clnr_pkg.sv -----
package clnr_pkg;

    // command codes carried on tuser of the input stream
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2
    } t_cmd;

    // address command nibbles
    localparam logic [3:0] NIB_LINE1    = 4'h8;
    localparam logic [3:0] NIB_LINE2    = 4'hC;
    localparam logic [3:0] NIB_ADDR_LOW = 4'h0;

    // character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

endpackage

// ----- rtl/core/char_lcd_nibble_refresh_top.sv -----
// Refresh controller for a 2-line character LCD in 4-bit mode. Characters are written into a
// text buffer (reset to spaces); a start command begins a refresh and each later tick word drives
// one nibble: line-1 address (8,0), characters high then low nibble with RS set, line-2 address
// (C,0) after LINE_CHARS characters, stopping after the last position or at a zero character.
// Every word yields one result word, registered and valid the cycle after its input word.
// One word is taken per clock cycle: the buffer memory has two registered read ports that keep
// the current and the following character ready, so a tick never waits on a read. A result word
// held by the output side stalls the input; the output register is freed in the cycle its word
// is taken, so words still flow back to back while the output side keeps taking them.
`include "char_lcd_nibble_refresh_top_defines.svh"

module char_lcd_nibble_refresh_top #(
    parameter int BUFFER_CHARS = 32,
    parameter int LINE_CHARS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [4:0] position, [12:5] char_code, [15:13] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] cmd
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [3:0] data_nibble, [4] enable, [5] busy_res,
                                         // [6] accepted, [7] zero
    output logic        o_m_axis_tuser   // [0] reg_select
);

    localparam int IW = (BUFFER_CHARS > 1) ? $clog2(BUFFER_CHARS) : 1;
    localparam logic [IW:0] BUF_LIM = (IW + 1)'(BUFFER_CHARS);

    // text buffer, per-entry valid bits stand for the reset value
    logic [7:0]              r_mem [BUFFER_CHARS];
    logic [BUFFER_CHARS-1:0] r_vld;

    // refresh state
    logic [IW-1:0] r_idx, n_idx;
    logic          r_low, n_low;
    logic          r_done, n_done;
    logic          r_busy, n_busy;
    logic [3:0]    r_nib, n_nib;
    logic          r_rs, n_rs;
    logic          r_stb, n_stb;
    logic          r_acc, n_acc;
    logic          r_just_inc, n_just_inc;
    logic          r_out_valid;

    // read data registers
    logic [7:0] r_rd_cur;
    logic [7:0] r_rd_nxt;

    logic          accept;
    clnr_pkg::t_cmd cmd;
    logic [4:0]    in_pos;
    logic [7:0]    in_char;
    logic          pos_ok;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic [IW:0]   nxt_full;
    logic          nxt_in;
    logic [IW-1:0] nxt_addr;
    logic [7:0]    cur_char;

    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign cmd     = clnr_pkg::t_cmd'(i_s_axis_tuser);
    assign in_pos  = i_s_axis_tdata[4:0];
    assign in_char = i_s_axis_tdata[12:5];
    assign pos_ok  = 32'(in_pos) < BUFFER_CHARS;
    assign wr_addr = IW'(in_pos);

    // following position for the look-ahead port
    assign nxt_full = {1'b0, r_idx} + (IW + 1)'(1);
    assign nxt_in   = nxt_full < BUF_LIM;
    assign nxt_addr = nxt_in ? nxt_full[IW-1:0] : '0;

    // right after a step the look-ahead port holds the new current character
    assign cur_char = r_just_inc ? r_rd_nxt : r_rd_cur;

    // output register is free or being emptied
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;

    // next-state logic for one word
    always_comb begin
        n_idx      = r_idx;
        n_low      = r_low;
        n_done     = r_done;
        n_busy     = r_busy;
        n_nib      = r_nib;
        n_rs       = r_rs;
        n_stb      = r_stb;
        n_acc      = 1'b0;
        n_just_inc = 1'b0;
        wr_en      = 1'b0;
        case (cmd)
            clnr_pkg::CMD_TICK: begin
                n_stb = 1'b0;
                if (r_busy) begin
                    if ((r_idx == '0 && !r_done) || (32'(r_idx) == LINE_CHARS && r_done)) begin
                        // line address command
                        n_stb = 1'b1;
                        if (!r_low) begin
                            n_rs  = 1'b0;
                            n_nib = r_done ? clnr_pkg::NIB_LINE2 : clnr_pkg::NIB_LINE1;
                            n_low = 1'b1;
                        end else begin
                            n_nib  = clnr_pkg::NIB_ADDR_LOW;
                            n_low  = 1'b0;
                            n_done = !r_done;
                        end
                    end else begin
                        // character nibble, then stop test
                        n_stb = 1'b1;
                        if (!r_low) begin
                            n_rs  = 1'b1;
                            n_nib = cur_char[7:4];
                            n_low = 1'b1;
                            if (cur_char == clnr_pkg::CHAR_NUL) begin
                                n_idx  = '0;
                                n_busy = 1'b0;
                                n_low  = 1'b0;
                                n_done = 1'b0;
                            end
                        end else begin
                            n_nib = cur_char[3:0];
                            n_low = 1'b0;
                            if (r_rd_nxt == clnr_pkg::CHAR_NUL) begin
                                n_idx  = '0;
                                n_busy = 1'b0;
                                n_done = 1'b0;
                            end else begin
                                n_idx      = nxt_full[IW-1:0];
                                n_just_inc = 1'b1;
                            end
                        end
                    end
                end
            end
            clnr_pkg::CMD_WRITE: begin
                if (!r_busy && pos_ok) begin
                    wr_en = 1'b1;
                    n_acc = 1'b1;
                end
            end
            clnr_pkg::CMD_START: begin
                if (!r_busy) begin
                    n_busy = 1'b1;
                    n_idx  = '0;
                    n_low  = 1'b0;
                    n_acc  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // buffer memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[wr_addr] <= in_char;
        end
        r_rd_cur <= r_vld[r_idx] ? r_mem[r_idx] : clnr_pkg::CHAR_SPACE;
        if (!nxt_in) begin
            r_rd_nxt <= clnr_pkg::CHAR_NUL;
        end else begin
            r_rd_nxt <= r_vld[nxt_addr] ? r_mem[nxt_addr] : clnr_pkg::CHAR_SPACE;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (accept && wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // control and pin registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_low       <= 1'b0;
            r_done      <= 1'b0;
            r_busy      <= 1'b0;
            r_nib       <= 4'h0;
            r_rs        <= 1'b0;
            r_stb       <= 1'b0;
            r_acc       <= 1'b0;
            r_just_inc  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_just_inc <= accept && n_just_inc;
            if (accept) begin
                r_idx       <= n_idx;
                r_low       <= n_low;
                r_done      <= n_done;
                r_busy      <= n_busy;
                r_nib       <= n_nib;
                r_rs        <= n_rs;
                r_stb       <= n_stb;
                r_acc       <= n_acc;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the pin registers only move on accept, so they hold while the result waits
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_acc, r_busy, r_stb, r_nib};
    assign o_m_axis_tuser  = r_rs;

    // checks
    `CLNR_ASSERT_NOW(a_idle_clean, !r_busy, (r_idx == '0) && !r_low && !r_done, "idle state not cleared")
    `CLNR_ASSERT_NOW(a_stall_blocks, r_out_valid && !i_m_axis_tready, !o_s_axis_tready, "input taken over a held result")
    `CLNR_ASSERT_NEXT(a_tick_strobes, accept && r_busy && (cmd == clnr_pkg::CMD_TICK), o_m_axis_tvalid && o_m_axis_tdata[4], "refresh tick without strobe")

endmodule

// ----- sim/tb_char_lcd_nibble_refresh_top.sv -----
module tb_char_lcd_nibble_refresh_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_CHARS = 32;
    localparam int LINE_LEN   = 16;
    // cmd code with no meaning; the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [4:0] pos;
        logic [7:0] code;
    } t_lcd_word;

    typedef struct {
        logic [3:0] nibble;
        logic       rs;
        logic       strobe;
        logic       busy;
        logic       taken;
    } t_lcd_pins;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;  // [4:0] position, [12:5] char_code, [15:13] zero
    logic [1:0]  i_s_axis_tuser = '0;  // [1:0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;       // [3:0] data_nibble, [4] enable, [5] busy_res,
                                       // [6] accepted, [7] zero
    logic        o_m_axis_tuser;       // [0] reg_select

    char_lcd_nibble_refresh_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_lcd_word pending_words[$];
    t_lcd_pins expected_pins[$];
    int        n_errors = 0;

    // shadow of the display controller
    logic [7:0] lcd_text[TEXT_CHARS];
    logic [5:0] lcd_index;
    logic       lcd_low_next;
    logic       lcd_addr_done;
    logic       lcd_busy;
    logic [3:0] lcd_nib;
    logic       lcd_rs;
    logic       lcd_strobe;

    function automatic logic [7:0] text_at(input logic [5:0] idx);
        if (idx < TEXT_CHARS) return lcd_text[idx];
        return clnr_pkg::CHAR_NUL;
    endfunction

    // address command: high nibble with RS low, then the zero low nibble
    function automatic void send_addr(input logic [3:0] high);
        lcd_strobe = 1'b1;
        if (!lcd_low_next) begin
            lcd_rs       = 1'b0;
            lcd_nib      = high;
            lcd_low_next = 1'b1;
        end else begin
            lcd_nib       = clnr_pkg::NIB_ADDR_LOW;
            lcd_low_next  = 1'b0;
            lcd_addr_done = !lcd_addr_done;
        end
    endfunction

    // advance the shadow by one word and return the pin levels after it
    function automatic t_lcd_pins lcd_step(input t_lcd_word w);
        t_lcd_pins  r;
        logic [7:0] ch;
        r.taken = 1'b0;
        case (w.cmd)
            clnr_pkg::CMD_TICK: begin
                lcd_strobe = 1'b0;
                if (lcd_busy) begin
                    if (lcd_index == 0 && !lcd_addr_done) begin
                        send_addr(clnr_pkg::NIB_LINE1);
                    end else if (lcd_index == LINE_LEN && lcd_addr_done) begin
                        send_addr(clnr_pkg::NIB_LINE2);
                    end else begin
                        ch = text_at(lcd_index);
                        lcd_strobe = 1'b1;
                        if (!lcd_low_next) begin
                            lcd_rs       = 1'b1;
                            lcd_nib      = ch[7:4];
                            lcd_low_next = 1'b1;
                        end else begin
                            lcd_nib      = ch[3:0];
                            lcd_low_next = 1'b0;
                            lcd_index    = lcd_index + 6'd1;
                        end
                        // end of buffer or a zero character ends the refresh
                        if (lcd_index >= TEXT_CHARS ||
                            text_at(lcd_index) == clnr_pkg::CHAR_NUL) begin
                            lcd_index     = '0;
                            lcd_busy      = 1'b0;
                            lcd_low_next  = 1'b0;
                            lcd_addr_done = 1'b0;
                        end
                    end
                end
            end
            clnr_pkg::CMD_WRITE: begin
                if (!lcd_busy && w.pos < TEXT_CHARS) begin
                    lcd_text[w.pos] = w.code;
                    r.taken = 1'b1;
                end
            end
            clnr_pkg::CMD_START: begin
                if (!lcd_busy) begin
                    lcd_busy     = 1'b1;
                    lcd_index    = '0;
                    lcd_low_next = 1'b0;
                    r.taken      = 1'b1;
                end
            end
            default: ;
        endcase
        r.nibble = lcd_nib;
        r.rs     = lcd_rs;
        r.strobe = lcd_strobe;
        r.busy   = lcd_busy;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return clnr_pkg::CHAR_NUL;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic push_word(input logic [1:0] cmd, input logic [4:0] pos,
                             input logic [7:0] code);
        t_lcd_word w;
        w.cmd  = cmd;
        w.pos  = pos;
        w.code = code;
        pending_words.push_back(w);
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            // occasional write or start that lands mid-refresh
            if ($urandom_range(0, 24) == 0)
                push_word(clnr_pkg::CMD_WRITE, 5'($urandom), rand_char());
            else if ($urandom_range(0, 39) == 0)
                push_word(clnr_pkg::CMD_START, 5'($urandom), 8'($urandom));
            push_word(clnr_pkg::CMD_TICK, 5'($urandom), 8'($urandom));
        end
    endtask

    // input driver
    t_lcd_word cur_word;
    int        in_gap = 0;
    int        in_pct = 0;
    int        in_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_pins.push_back(lcd_step(cur_word));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {3'b000, cur_word.code, cur_word.pos};
                    i_s_axis_tuser  <= cur_word.cmd;
                    if (in_count % 64 == 0) in_pct = ($urandom_range(0, 2) == 0) ? 0 :
                                                     $urandom_range(10, 60);
                    in_count++;
                    in_gap = pick_gap(in_pct);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            n_errors++;
        end
    endtask

    // result monitor and output back-pressure
    t_lcd_pins want_pins;
    int        out_gap = 0;
    int        out_pct = 0;
    int        out_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_pins.size() == 0) begin
                $display("%0t: result word with none expected, actual data %0h user %0h",
                         $realtime, o_m_axis_tdata, o_m_axis_tuser);
                n_errors++;
            end else begin
                want_pins = expected_pins.pop_front();
                check_field("data_nibble", int'(want_pins.nibble), int'(o_m_axis_tdata[3:0]));
                check_field("enable", int'(want_pins.strobe), int'(o_m_axis_tdata[4]));
                check_field("busy_res", int'(want_pins.busy), int'(o_m_axis_tdata[5]));
                check_field("accepted", int'(want_pins.taken), int'(o_m_axis_tdata[6]));
                check_field("reg_select", int'(want_pins.rs), int'(o_m_axis_tuser));
            end
        end
        if (out_cycles % 128 == 0) out_pct = ($urandom_range(0, 2) == 0) ? 0 :
                                             $urandom_range(5, 40);
        out_cycles++;
        if (out_gap > 0) begin
            out_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            out_gap = pick_gap(out_pct);
        end
    end

    // stimulus and end of run
    initial begin
        int n_seq;
        for (int i = 0; i < TEXT_CHARS; i++) lcd_text[i] = clnr_pkg::CHAR_SPACE;
        lcd_index     = '0;
        lcd_low_next  = 1'b0;
        lcd_addr_done = 1'b0;
        lcd_busy      = 1'b0;
        lcd_nib       = '0;
        lcd_rs        = 1'b0;
        lcd_strobe    = 1'b0;

        // directed: idle tick, unused code, short refresh stopped by a zero
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(CMD_UNUSED, 5'd31, 8'hFF);
        push_word(clnr_pkg::CMD_WRITE, 5'd1, clnr_pkg::CHAR_NUL);
        push_word(clnr_pkg::CMD_WRITE, 5'd0, 8'hFF);
        push_word(clnr_pkg::CMD_START, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_START, 5'd0, 8'h00);      // ignored while refreshing
        push_word(clnr_pkg::CMD_WRITE, 5'd31, 8'h5A);     // ignored while refreshing
        push_word(CMD_UNUSED, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);       // E drops after refresh
        // zero at position 0: its high nibble still goes out
        push_word(clnr_pkg::CMD_WRITE, 5'd0, clnr_pkg::CHAR_NUL);
        push_word(clnr_pkg::CMD_START, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_TICK, 5'd0, 8'h00);
        push_word(clnr_pkg::CMD_WRITE, 5'd0, 8'hA5);
        push_word(clnr_pkg::CMD_WRITE, 5'd1, 8'h5A);
        push_word(clnr_pkg::CMD_WRITE, 5'd31, 8'h01);

        // random: mostly write, start, tick run; some noise
        while (pending_words.size() < 900) begin
            if ($urandom_range(0, 99) < 85) begin
                n_seq = $urandom_range(0, 5);
                for (int i = 0; i < n_seq; i++)
                    push_word(clnr_pkg::CMD_WRITE, 5'($urandom), rand_char());
                push_word(clnr_pkg::CMD_START, 5'($urandom), 8'($urandom));
                if ($urandom_range(0, 9) < 7) push_ticks($urandom_range(68, 80));
                else push_ticks($urandom_range(0, 40));
            end else begin
                n_seq = $urandom_range(1, 6);
                for (int i = 0; i < n_seq; i++)
                    push_word(2'($urandom_range(0, 3)), 5'($urandom), 8'($urandom));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || i_s_axis_tvalid || expected_pins.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_pins.size() != 0) begin
            $display("%0t: expected %0d more result words, actual 0",
                     $realtime, expected_pins.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
